// File: rtl/core/iee_pkg.sv
// Package for the infix expression evaluator: word width, operator codes,
// sequencer states and byte decode helpers. Depends on nothing.
`timescale 1ns / 1ps

package iee_pkg;

    // Arithmetic word width and the width of the divider step counter.
    localparam int WORD_W    = 32;
    localparam int DIV_CNT_W = $clog2(WORD_W);

    // Character constants used by the byte decoder.
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_DIVIDE = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Pending operator codes.
    typedef enum logic [2:0] {
        OP_PLUS    = 3'd0,
        OP_MINUS   = 3'd1,
        OP_TIMES   = 3'd2,
        OP_DIVIDE  = 3'd3,
        OP_UNKNOWN = 3'd4
    } op_code_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DIV,
        ST_FIX,
        ST_FINISH
    } state_t;

    // Map an expression byte to its operator code.
    function automatic op_code_t code_of(input logic [7:0] c);
        op_code_t code;
        unique case (c)
            CH_PLUS:   code = OP_PLUS;
            CH_MINUS:  code = OP_MINUS;
            CH_TIMES:  code = OP_TIMES;
            CH_DIVIDE: code = OP_DIVIDE;
            default:   code = OP_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/core/infix_expression_evaluator.sv
// Sequencing: a digit or whitespace byte is taken in ST_IDLE; an operator or final byte
// goes through ST_APPLY, and a division by a nonzero number also through ST_DIV, the
// one-bit-per-cycle restoring divider, and ST_FIX. A final byte then waits in ST_FINISH
// to load the output register. No new byte is taken until the block is back in ST_IDLE.
// Reset (rst_n, asynchronous, active low) clears the sum, term, number, operator
// and error flag, and empties the output register.
`timescale 1ns / 1ps

// Top level: byte-serial infix evaluator with a shared iterative divider.
// Depends on iee_pkg.
module infix_expression_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic        m_tuser    // [0] divide_by_zero
);
    import iee_pkg::*;

    state_t                 state_reg, state_next;
    logic [WORD_W-1:0]      sum_reg, sum_next;
    logic [WORD_W-1:0]      term_reg, term_next;
    logic [WORD_W-1:0]      cur_reg, cur_next;
    op_code_t               op_reg, op_next;
    op_code_t               code_reg, code_next;
    logic                   dz_reg, dz_next;
    logic                   last_reg, last_next;
    logic [WORD_W-1:0]      rem_reg, rem_next;
    logic [WORD_W-1:0]      quo_reg, quo_next;
    logic [WORD_W-1:0]      dvs_reg, dvs_next;
    logic                   neg_reg, neg_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_value_reg, out_value_next;
    logic                   out_dz_reg, out_dz_next;

    logic                   in_xfer;
    logic                   is_digit;
    logic                   is_space;
    logic [WORD_W-1:0]      digit_val;
    logic [WORD_W:0]        div_shift;
    logic [WORD_W:0]        div_diff;
    logic [WORD_W-1:0]      result_word;

    // Byte classification.
    assign is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign is_space  = (s_tdata == CH_SPACE) || ((s_tdata >= CH_TAB) && (s_tdata <= CH_CR));
    assign digit_val = WORD_W'(s_tdata - CH_ZERO);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // One restoring divider step: shift in the next dividend bit and trial subtract.
    assign div_shift = {rem_reg, quo_reg[WORD_W-1]};
    assign div_diff  = div_shift - {1'b0, dvs_reg};

    assign result_word = sum_reg + term_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_dz_reg;

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            term_reg      <= '0;
            cur_reg       <= '0;
            op_reg        <= OP_PLUS;
            code_reg      <= OP_PLUS;
            dz_reg        <= 1'b0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            cur_reg       <= cur_next;
            op_reg        <= op_next;
            code_reg      <= code_next;
            dz_reg        <= dz_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Divider and output payload registers need no reset.
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        neg_reg       <= neg_next;
        out_value_reg <= out_value_next;
        out_dz_reg    <= out_dz_next;
    end

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        term_next      = term_reg;
        cur_next       = cur_reg;
        op_next        = op_reg;
        code_next      = code_reg;
        dz_next        = dz_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_dz_next    = out_dz_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // Digits accumulate as number * 10 + digit, built from two shifts.
                    if (is_digit)
                    begin
                        cur_next = (cur_reg << 3) + (cur_reg << 1) + digit_val;
                    end
                    if ((!is_digit && !is_space) || s_tlast)
                    begin
                        code_next  = code_of(s_tdata);
                        last_next  = s_tlast;
                        state_next = ST_APPLY;
                    end
                end
            end

            ST_APPLY:
            begin
                // Apply the pending operator to the finished number.
                state_next = last_reg ? ST_FINISH : ST_IDLE;
                unique case (op_reg)
                    OP_PLUS:
                    begin
                        sum_next  = sum_reg + term_reg;
                        term_next = cur_reg;
                    end
                    OP_MINUS:
                    begin
                        sum_next  = sum_reg + term_reg;
                        term_next = -cur_reg;
                    end
                    OP_TIMES:
                    begin
                        term_next = term_reg * cur_reg;
                    end
                    OP_DIVIDE:
                    begin
                        if (cur_reg == '0)
                        begin
                            term_next = '0;
                            dz_next   = 1'b1;
                        end
                        else
                        begin
                            // Divide magnitudes, fix the sign afterwards.
                            quo_next   = term_reg[WORD_W-1] ? -term_reg : term_reg;
                            dvs_next   = cur_reg[WORD_W-1] ? -cur_reg : cur_reg;
                            rem_next   = '0;
                            neg_next   = term_reg[WORD_W-1] ^ cur_reg[WORD_W-1];
                            cnt_next   = DIV_CNT_W'(WORD_W - 1);
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        // An unknown operator drops the number.
                    end
                endcase
                op_next  = code_reg;
                cur_next = '0;
            end

            ST_DIV:
            begin
                if (!div_diff[WORD_W])
                begin
                    rem_next = div_diff[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
            end

            ST_FIX:
            begin
                // Truncating division: the quotient takes the sign difference.
                term_next  = neg_reg ? -quo_reg : quo_reg;
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end

            ST_FINISH:
            begin
                // Load the result once the output register is free, then start afresh.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = 32'(signed'(result_word));
                    out_dz_next    = dz_reg;
                    sum_next       = '0;
                    term_next      = '0;
                    cur_next       = '0;
                    op_next        = OP_PLUS;
                    dz_next        = 1'b0;
                    last_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: tb/tb_infix_expression_evaluator.sv
// Self-checking testbench for the infix expression evaluator: directed and random
// expressions streamed byte by byte, results predicted in-bench and checked in order.
// Depends on iee_pkg and infix_expression_evaluator.
`timescale 1ns / 1ps

module tb_infix_expression_evaluator;

    import iee_pkg::*;

    localparam int RANDOM_BYTES = 700;
    localparam int QUIET_TAIL   = 100;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;

    // One expression byte as offered on the input stream.
    typedef struct {
        logic [7:0] code;
        logic       lst;
    } expr_byte_t;

    // One expected expression result.
    typedef struct {
        logic [31:0] value;
        logic        div0;
    } expr_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    expr_byte_t   byte_queue[$];
    expr_result_t expected_results[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           results_seen = 0;

    // Evaluator state as the predictor sees it.
    logic [31:0]  acc_sum    = '0;
    logic [31:0]  acc_term   = '0;
    logic [31:0]  acc_number = '0;
    op_code_t     acc_op     = OP_PLUS;
    logic         acc_div0   = 1'b0;

    infix_expression_evaluator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // Fold one accepted byte into the predicted state; a final byte yields a result.
    task automatic evaluate_byte(input logic [7:0] c, input logic lst);
        logic         is_digit;
        logic         is_space;
        logic [31:0]  mag_a;
        logic [31:0]  mag_b;
        logic [31:0]  quo;
        expr_result_t res;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        if (is_digit)
        begin
            acc_number = acc_number * 32'd10 + (32'(c) - 32'(CH_ZERO));
        end
        if ((!is_digit && !is_space) || lst)
        begin
            case (acc_op)
                OP_PLUS:
                begin
                    acc_sum  = acc_sum + acc_term;
                    acc_term = acc_number;
                end
                OP_MINUS:
                begin
                    acc_sum  = acc_sum + acc_term;
                    acc_term = 32'd0 - acc_number;
                end
                OP_TIMES:
                begin
                    acc_term = acc_term * acc_number;
                end
                OP_DIVIDE:
                begin
                    if (acc_number == 32'd0)
                    begin
                        acc_term = 32'd0;
                        acc_div0 = 1'b1;
                    end
                    else
                    begin
                        // Divide magnitudes, then restore the sign; wraps like the block.
                        mag_a = acc_term[31] ? 32'd0 - acc_term : acc_term;
                        mag_b = acc_number[31] ? 32'd0 - acc_number : acc_number;
                        quo   = mag_a / mag_b;
                        if (acc_term[31] ^ acc_number[31])
                        begin
                            quo = 32'd0 - quo;
                        end
                        acc_term = quo;
                    end
                end
                default:
                begin
                    // Unknown operator: the number is dropped, sum and term stay.
                end
            endcase
            case (c)
                CH_PLUS:   acc_op = OP_PLUS;
                CH_MINUS:  acc_op = OP_MINUS;
                CH_TIMES:  acc_op = OP_TIMES;
                CH_DIVIDE: acc_op = OP_DIVIDE;
                default:   acc_op = OP_UNKNOWN;
            endcase
            acc_number = 32'd0;
        end
        if (lst)
        begin
            res.value = acc_sum + acc_term;
            res.div0  = acc_div0;
            expected_results.insert(expected_results.size(), res);
            acc_sum    = '0;
            acc_term   = '0;
            acc_number = '0;
            acc_op     = OP_PLUS;
            acc_div0   = 1'b0;
        end
    endtask

    // Queue a text as expression bytes, optionally marking its final byte.
    task automatic push_text(input string s, input logic mark_end);
        for (int i = 0; i < s.len(); i++)
        begin
            byte_queue.insert(byte_queue.size(), '{s[i], mark_end && (i == s.len() - 1)});
        end
    endtask

    // Random whitespace byte: tab through carriage return, or space.
    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
    endfunction

    // Random arithmetic operator byte.
    function automatic logic [7:0] operator_byte();
        logic [7:0] ops[4];
        ops = '{CH_PLUS, CH_MINUS, CH_TIMES, CH_DIVIDE};
        return ops[$urandom_range(0, 3)];
    endfunction

    // Build one random expression: mostly well formed, some noise or broken ones.
    task automatic gen_expression();
        int         kind;
        int         n_terms;
        int         n_digits;
        int         r;
        expr_byte_t bytes[$];
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6))
                bytes.insert(bytes.size(), '{8'($urandom_range(0, 255)), 1'b0});
        end
        else
        begin
            n_terms = $urandom_range(1, 6);
            for (int t = 0; t < n_terms; t++)
            begin
                if (t > 0)
                begin
                    if ($urandom_range(0, 19) == 0)
                        bytes.insert(bytes.size(), '{8'($urandom_range(0, 255)), 1'b0});
                    else
                        bytes.insert(bytes.size(), '{operator_byte(), 1'b0});
                end
                if ($urandom_range(0, 3) == 0)
                    bytes.insert(bytes.size(), '{blank_byte(), 1'b0});
                // Number size: mostly one or two digits, sometimes a lone zero or long enough to wrap.
                r = $urandom_range(0, 9);
                if (r == 0)
                    n_digits = 0;
                else if (r == 1)
                    n_digits = $urandom_range(8, 11);
                else
                    n_digits = $urandom_range(1, 2);
                if (n_digits == 0)
                    bytes.insert(bytes.size(), '{CH_ZERO, 1'b0});
                repeat (n_digits)
                    bytes.insert(bytes.size(),
                                 '{8'(CH_ZERO + $urandom_range(0, 9)), 1'b0});
                if ($urandom_range(0, 4) == 0)
                    bytes.insert(bytes.size(), '{blank_byte(), 1'b0});
            end
            // Final byte may be a digit, an operator, whitespace or any byte at all.
            r = $urandom_range(0, 7);
            if (r == 0)
                bytes.insert(bytes.size(), '{operator_byte(), 1'b0});
            else if (r == 1)
                bytes.insert(bytes.size(), '{blank_byte(), 1'b0});
            else if (r == 2)
                bytes.insert(bytes.size(), '{8'($urandom_range(0, 255)), 1'b0});
            if (kind == 1)
                bytes.insert($urandom_range(0, bytes.size() - 1),
                             '{8'($urandom_range(0, 255)), 1'b0});
        end
        bytes[bytes.size() - 1].lst = 1'b1;
        foreach (bytes[i])
            byte_queue.insert(byte_queue.size(), bytes[i]);
    endtask

    // Driver: offers queued bytes, idles in random bursts, predicts on acceptance.
    int drv_idle_left = 0;
    int drv_gap_pct   = 10;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                evaluate_byte(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready)
            begin
                if ($urandom_range(0, 49) == 0)
                begin
                    drv_gap_pct = ($urandom_range(0, 2) == 0) ? 0 :
                                  (($urandom_range(0, 1) == 0) ? 10 : 35);
                end
                if (drv_idle_left > 0)
                begin
                    drv_idle_left--;
                    s_tvalid <= 1'b0;
                end
                else if (byte_queue.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                end
                else if (byte_queue.size() > QUIET_TAIL &&
                         $urandom_range(0, 99) < drv_gap_pct)
                begin
                    drv_idle_left = $urandom_range(1, 7) - 1;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_queue[0].code;
                    s_tlast  <= byte_queue[0].lst;
                    void'(byte_queue.pop_front());
                end
            end
        end
    end

    // Monitor: checks each result transaction, stalls in bursts and once for long.
    int   rcv_idle_left = 0;
    int   rcv_hold_left = 0;
    int   rcv_gap_pct   = 10;
    logic pressure_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        expr_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result value=%h div0=%b",
                             $realtime, m_tdata, m_tuser);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        $display("%0t: value mismatch expected %h actual %h",
                                 $realtime, want.value, m_tdata);
                        error_count++;
                    end
                    if (m_tuser !== want.div0)
                    begin
                        $display("%0t: divide_by_zero mismatch expected %b actual %b",
                                 $realtime, want.div0, m_tuser);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 49) == 0)
            begin
                rcv_gap_pct = ($urandom_range(0, 2) == 0) ? 0 :
                              (($urandom_range(0, 1) == 0) ? 10 : 35);
            end
            if (rcv_hold_left > 0)
            begin
                rcv_hold_left--;
                m_tready <= 1'b0;
            end
            else if (!pressure_done && results_seen >= 10)
            begin
                // Long back-pressure so the block fills and stalls its input.
                pressure_done = 1'b1;
                rcv_hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else if (rcv_idle_left > 0)
            begin
                rcv_idle_left--;
                m_tready <= 1'b0;
            end
            else if (byte_queue.size() > QUIET_TAIL &&
                     $urandom_range(0, 99) < rcv_gap_pct)
            begin
                rcv_idle_left = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("infix_expression_evaluator regression: fail");
            $finish;
        end
    end

    // Stimulus setup, reset and end of run.
    initial
    begin
        int directed_len;
        // Digit wrap to -1 and the most negative value divided by -1.
        push_text("2147483648/42949672959", 1'b1);
        // Precedence, with an unknown top-bit byte as the final byte.
        push_text("7*3-8/2", 1'b0);
        byte_queue.insert(byte_queue.size(), '{8'hFF, 1'b1});
        // Division by zero, ended on a whitespace byte.
        push_text("9/0\t", 1'b1);
        // Unknown operator drops the number that follows it.
        push_text("5#3+1", 1'b1);
        // Lowest byte value alone as a whole expression.
        byte_queue.insert(byte_queue.size(), '{8'h00, 1'b1});
        directed_len = byte_queue.size();
        while (byte_queue.size() < directed_len + RANDOM_BYTES)
            gen_expression();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("infix_expression_evaluator regression: pass");
        else
            $display("infix_expression_evaluator regression: fail");
        $finish;
    end

endmodule
